// File: rtl/assert_macros.svh
// assertion macros for the rtl files; prl_state uses them
// no dependencies; each file that asserts includes this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define PRL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// clocked assertion that is checked during reset as well
`define PRL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// File: rtl/prl_pkg.sv
// types, constants and helper functions of the pedal ramp and button edge latch
// no dependencies
package prl_pkg;

    localparam int RATE_W  = 20;
    localparam int LEVEL_W = 16;
    localparam int STEER_W = 17;
    localparam int FLAG_W  = 22;
    localparam int PREV_W  = 24;
    localparam int BTN_W   = 32;
    localparam int ELAP_W  = 16;
    localparam int IDX_W   = 2;

    localparam logic [LEVEL_W-1:0]        ONE_Q15   = 16'd32768;
    localparam logic [RATE_W-1:0]         RATE_RST  = 20'd32768;
    localparam logic signed [STEER_W-1:0] STEER_MAX = 17'sd32768;
    localparam logic signed [STEER_W-1:0] STEER_MIN = -17'sd32768;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_CONSUME = 1'b1;

    localparam logic [IDX_W-1:0] REG_THROTTLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_BRAKE    = 2'd1;
    localparam logic [IDX_W-1:0] REG_STEER    = 2'd2;
    localparam logic [IDX_W-1:0] REG_RETURN   = 2'd3;

    localparam int B_PANEL0    = 18;
    localparam int B_SPACE     = 22;
    localparam int B_RESET     = 23;
    localparam int B_THROTTLE  = 24;
    localparam int B_BRAKE     = 25;
    localparam int B_LEFT      = 26;
    localparam int B_RIGHT     = 27;
    localparam int B_ESC       = 28;
    localparam int B_HORN_BOTH = 29;
    localparam int B_TONE_LOW  = 30;
    localparam int B_TONE_HIGH = 31;
    localparam int MAX_PANELS  = 4;

    typedef struct packed {
        logic [RATE_W-1:0] throttle;
        logic [RATE_W-1:0] brake;
        logic [RATE_W-1:0] steer;
        logic [RATE_W-1:0] steer_return;
    } t_rates;

    typedef struct packed {
        logic              kind;
        logic [BTN_W-1:0]  buttons;
        logic [ELAP_W-1:0] elapsed;
        logic [FLAG_W-1:0] mask;
    } t_item;

    typedef struct packed {
        logic               kind;
        logic [BTN_W-1:0]   buttons;
        logic [FLAG_W-1:0]  mask;
        logic [LEVEL_W-1:0] throttle;
        logic [LEVEL_W-1:0] brake;
        logic [LEVEL_W-1:0] steer;
        logic [LEVEL_W-1:0] steer_return;
    } t_step;

    // rate times dt in q1.15, saturated at one
    function automatic logic [LEVEL_W-1:0] step_of(input logic [RATE_W-1:0] rate,
                                                   input logic [ELAP_W-1:0] dt);
        logic [RATE_W+ELAP_W-1:0] prod;
        logic [RATE_W-1:0]        hi;
        prod = rate * dt;
        hi   = prod[RATE_W+ELAP_W-1:ELAP_W];
        if (hi > RATE_W'(ONE_Q15)) begin
            return ONE_Q15;
        end
        return hi[LEVEL_W-1:0];
    endfunction

    // flags that can ever be set for a given panel count
    function automatic logic [FLAG_W-1:0] valid_flags(input int panels);
        logic [FLAG_W-1:0] m;
        m = FLAG_W'(18'h3FFFF);
        for (int p = 0; p < MAX_PANELS; p++) begin
            if (p < panels) begin
                m[B_PANEL0+p] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/pedal_ramp_and_button_edge_latch_unit.sv
// pedal ramp and button edge latch: rate registers, step stage and state stage
// a transaction passes the input, step and state registers before its result is valid
// throughput: one item per cycle unless the output stalls; the four 20x16 step multiplies own one stage
// reset (synchronous, active low): levels, flags and history cleared, rates 32768
// depends on prl_pkg, prl_step and prl_state
module pedal_ramp_and_button_edge_latch_unit import prl_pkg::*; #(
    parameter int PANEL_COUNT = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [IDX_W-1:0]          i_cfg_idx,
    input  logic [RATE_W-1:0]         i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_kind,
    input  logic [BTN_W-1:0]          i_buttons,
    input  logic [ELAP_W-1:0]         i_elapsed,
    input  logic [FLAG_W-1:0]         i_consume_mask,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [LEVEL_W-1:0]        o_throttle_out,
    output logic [LEVEL_W-1:0]        o_brake_out,
    output logic signed [STEER_W-1:0] o_steering_out,
    output logic                      o_park_brake,
    output logic                      o_reset_pulse,
    output logic                      o_tone_low,
    output logic                      o_tone_high,
    output logic                      o_quit_flag,
    output logic [FLAG_W-1:0]         o_pending_out
);

    t_rates r_rates;
    t_item  in_item;
    t_step  step;
    logic   step_valid;
    logic   step_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rates.throttle     <= RATE_RST;
            r_rates.brake        <= RATE_RST;
            r_rates.steer        <= RATE_RST;
            r_rates.steer_return <= RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THROTTLE: r_rates.throttle     <= i_cfg_data;
                REG_BRAKE:    r_rates.brake        <= i_cfg_data;
                REG_STEER:    r_rates.steer        <= i_cfg_data;
                REG_RETURN:   r_rates.steer_return <= i_cfg_data;
                default:      r_rates.throttle     <= r_rates.throttle;
            endcase
        end
    end

    always_comb begin
        in_item.kind    = i_kind;
        in_item.buttons = i_buttons;
        in_item.elapsed = i_elapsed;
        in_item.mask    = i_consume_mask;
    end

    prl_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_rates (r_rates),
        .o_valid (step_valid),
        .i_ready (step_ready),
        .o_step  (step)
    );

    prl_state #(
        .PANEL_COUNT (PANEL_COUNT)
    ) u_state (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (step_valid),
        .o_ready         (step_ready),
        .i_step          (step),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_throttle_out  (o_throttle_out),
        .o_brake_out     (o_brake_out),
        .o_steering_out  (o_steering_out),
        .o_park_brake    (o_park_brake),
        .o_reset_pulse   (o_reset_pulse),
        .o_tone_low      (o_tone_low),
        .o_tone_high     (o_tone_high),
        .o_quit_flag     (o_quit_flag),
        .o_pending_out   (o_pending_out)
    );

endmodule

// File: rtl/prl_step.sv
// input register and step stage: four rate-times-dt products, saturated
// depends on prl_pkg
module prl_step import prl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_item            i_item,
    input  t_rates           i_rates,
    output logic             o_valid,
    input  logic             i_ready,
    output t_step            o_step
);

    logic  r_in_valid;
    t_item r_in;
    logic  r_st_valid;
    t_step r_st;
    t_step n_st;
    logic  st_load;
    logic  in_load;

    assign st_load = !r_st_valid || i_ready;
    assign in_load = !r_in_valid || st_load;

    always_comb begin
        n_st.kind         = r_in.kind;
        n_st.buttons      = r_in.buttons;
        n_st.mask         = r_in.mask;
        n_st.throttle     = step_of(i_rates.throttle, r_in.elapsed);
        n_st.brake        = step_of(i_rates.brake, r_in.elapsed);
        n_st.steer        = step_of(i_rates.steer, r_in.elapsed);
        n_st.steer_return = step_of(i_rates.steer_return, r_in.elapsed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (st_load) begin
                r_st_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_in <= i_item;
        end
        if (st_load && r_in_valid) begin
            r_st <= n_st;
        end
    end

    assign o_ready = in_load;
    assign o_valid = r_st_valid;
    assign o_step  = r_st;

endmodule

// File: rtl/prl_state.sv
// level, edge and flag state with the result register
// depends on prl_pkg and assert_macros.svh
`include "assert_macros.svh"

module prl_state import prl_pkg::*; #(
    parameter int PANEL_COUNT = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_step                     i_step,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [LEVEL_W-1:0]        o_throttle_out,
    output logic [LEVEL_W-1:0]        o_brake_out,
    output logic signed [STEER_W-1:0] o_steering_out,
    output logic                      o_park_brake,
    output logic                      o_reset_pulse,
    output logic                      o_tone_low,
    output logic                      o_tone_high,
    output logic                      o_quit_flag,
    output logic [FLAG_W-1:0]         o_pending_out
);

    localparam logic [FLAG_W-1:0] VALID_MASK = valid_flags(PANEL_COUNT);

    logic [LEVEL_W-1:0]        r_throttle, n_throttle;
    logic [LEVEL_W-1:0]        r_brake, n_brake;
    logic signed [STEER_W-1:0] r_steer, n_steer;
    logic                      r_park, n_park;
    logic [PREV_W-1:0]         r_prev, n_prev;
    logic [FLAG_W-1:0]         r_pending, n_pending;
    logic                      r_quit, n_quit;

    logic                      r_out_valid;
    logic                      r_out_reset, n_out_reset;
    logic                      r_out_hlow, n_out_hlow;
    logic                      r_out_hhigh, n_out_hhigh;
    logic [FLAG_W-1:0]         r_out_pend, n_out_pend;

    logic                      take;
    logic                      out_load;
    logic [PREV_W-1:0]         rise;
    logic signed [STEER_W+1:0] s_ext;
    logic signed [STEER_W+1:0] s_add;
    logic signed [STEER_W+1:0] s_sub;
    logic signed [STEER_W+1:0] s_add_ret;
    logic signed [STEER_W+1:0] s_sub_ret;

    function automatic logic [LEVEL_W-1:0] ramp(input logic [LEVEL_W-1:0] lvl,
                                                input logic [LEVEL_W-1:0] st,
                                                input logic up);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, lvl} + {1'b0, st};
        if (up) begin
            return (sum > {1'b0, ONE_Q15}) ? ONE_Q15 : sum[LEVEL_W-1:0];
        end
        return (lvl > st) ? (lvl - st) : '0;
    endfunction

    assign out_load = !r_out_valid || i_ready;
    assign take     = i_valid && out_load;

    assign rise      = i_step.buttons[PREV_W-1:0] & ~r_prev;
    assign s_ext     = {{2{r_steer[STEER_W-1]}}, r_steer};
    assign s_add     = s_ext + $signed({3'b0, i_step.steer});
    assign s_sub     = s_ext - $signed({3'b0, i_step.steer});
    assign s_add_ret = s_ext + $signed({3'b0, i_step.steer_return});
    assign s_sub_ret = s_ext - $signed({3'b0, i_step.steer_return});

    always_comb begin
        n_throttle  = r_throttle;
        n_brake     = r_brake;
        n_steer     = r_steer;
        n_park      = r_park;
        n_prev      = r_prev;
        n_pending   = r_pending;
        n_quit      = r_quit;
        n_out_reset = 1'b0;
        n_out_hlow  = 1'b0;
        n_out_hhigh = 1'b0;
        n_out_pend  = r_pending & i_step.mask;
        if (i_step.kind == KIND_TICK) begin
            n_throttle = ramp(r_throttle, i_step.throttle, i_step.buttons[B_THROTTLE]);
            n_brake    = ramp(r_brake, i_step.brake, i_step.buttons[B_BRAKE]);
            if (i_step.buttons[B_LEFT]) begin
                n_steer = (s_add > 19'(STEER_MAX)) ? STEER_MAX : s_add[STEER_W-1:0];
            end else if (i_step.buttons[B_RIGHT]) begin
                n_steer = (s_sub < 19'(STEER_MIN)) ? STEER_MIN : s_sub[STEER_W-1:0];
            end else if (r_steer > 0) begin
                n_steer = (s_sub_ret < 0) ? '0 : s_sub_ret[STEER_W-1:0];
            end else begin
                n_steer = (s_add_ret > 0) ? '0 : s_add_ret[STEER_W-1:0];
            end
            n_park      = r_park ^ rise[B_SPACE];
            n_prev      = i_step.buttons[PREV_W-1:0];
            n_pending   = r_pending | (rise[FLAG_W-1:0] & VALID_MASK);
            n_quit      = r_quit | i_step.buttons[B_ESC];
            n_out_reset = rise[B_RESET];
            n_out_hlow  = i_step.buttons[B_HORN_BOTH] | i_step.buttons[B_TONE_LOW];
            n_out_hhigh = i_step.buttons[B_HORN_BOTH] | i_step.buttons[B_TONE_HIGH];
            n_out_pend  = n_pending;
        end else begin
            n_pending = r_pending & ~i_step.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_throttle  <= '0;
            r_brake     <= '0;
            r_steer     <= '0;
            r_park      <= 1'b0;
            r_prev      <= '0;
            r_pending   <= '0;
            r_quit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= i_valid;
            end
            if (take) begin
                r_throttle <= n_throttle;
                r_brake    <= n_brake;
                r_steer    <= n_steer;
                r_park     <= n_park;
                r_prev     <= n_prev;
                r_pending  <= n_pending;
                r_quit     <= n_quit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_reset <= n_out_reset;
            r_out_hlow  <= n_out_hlow;
            r_out_hhigh <= n_out_hhigh;
            r_out_pend  <= n_out_pend;
        end
    end

    assign o_ready         = out_load;
    assign o_valid         = r_out_valid;
    assign o_throttle_out  = r_throttle;
    assign o_brake_out     = r_brake;
    assign o_steering_out  = r_steer;
    assign o_park_brake    = r_park;
    assign o_reset_pulse   = r_out_reset;
    assign o_tone_low      = r_out_hlow;
    assign o_tone_high     = r_out_hhigh;
    assign o_quit_flag     = r_quit;
    assign o_pending_out   = r_out_pend;

    `PRL_ASSERT(a_throttle_in_range, r_throttle <= ONE_Q15, "throttle out of range")
    `PRL_ASSERT(a_brake_in_range, r_brake <= ONE_Q15, "brake out of range")
    `PRL_ASSERT(a_steer_in_range, r_steer <= STEER_MAX && r_steer >= STEER_MIN, "steer range")
    `PRL_ASSERT(a_no_absent_panel_flag, (r_pending & ~VALID_MASK) == '0, "absent panel flag")
    `PRL_ASSERT(a_quit_sticky, r_quit |=> r_quit, "quit flag cleared")
    `PRL_ASSERT(a_idle_hold, !take |=> $stable(r_pending) && $stable(r_steer), "moved while idle")

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for pedal_ramp_and_button_edge_latch_unit: directed table, then random phases
// under several rate settings; each result checked against the table or a control model
// depends on prl_pkg and the rtl of the unit
module tb;
    import prl_pkg::*;

    localparam int PANELS = 4;
    localparam int FULL = 32768;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 175;
    localparam logic [RATE_W-1:0] RATE_MAX = 20'hFFFFF;
    localparam logic [FLAG_W-1:0] LIVE_FLAGS = FLAG_W'(18'h3FFFF)
        | FLAG_W'(((1 << (PANELS < MAX_PANELS ? PANELS : MAX_PANELS)) - 1) << B_PANEL0);

    localparam logic [BTN_W-1:0] ALL_KEYS = '1;
    localparam logic [BTN_W-1:0] KEY_THROTTLE = BTN_W'(1) << B_THROTTLE;
    localparam logic [BTN_W-1:0] KEY_BRAKE = BTN_W'(1) << B_BRAKE;
    localparam logic [BTN_W-1:0] KEY_LEFT = BTN_W'(1) << B_LEFT;
    localparam logic [BTN_W-1:0] KEY_RIGHT = BTN_W'(1) << B_RIGHT;
    localparam logic [BTN_W-1:0] KEY_PARK = BTN_W'(1) << B_SPACE;
    localparam logic [BTN_W-1:0] KEY_RESET = BTN_W'(1) << B_RESET;
    localparam logic [BTN_W-1:0] KEY_HORN_BOTH = BTN_W'(1) << B_HORN_BOTH;
    localparam logic [BTN_W-1:0] KEY_TONE_LOW = BTN_W'(1) << B_TONE_LOW;
    localparam logic [BTN_W-1:0] KEY_TONE_HIGH = BTN_W'(1) << B_TONE_HIGH;

    localparam logic [IDX_W-1:0] REG_ORDER [4] = '{REG_THROTTLE, REG_BRAKE, REG_STEER, REG_RETURN};

    typedef struct packed {
        logic [LEVEL_W-1:0] throttle;
        logic [LEVEL_W-1:0] brake;
        logic [STEER_W-1:0] steer;
        logic               park;
        logic               rst_pulse;
        logic               horn_lo;
        logic               horn_hi;
        logic               quit;
        logic [FLAG_W-1:0]  pend;
    } t_controls;

    typedef struct packed {
        t_item     it;
        logic      typed;
        t_controls want;
    } t_row;

    localparam t_controls NONE = '0;

    localparam t_row SCRIPT [26] = '{
        '{'{KIND_CONSUME, ALL_KEYS, 16'hFFFF, 22'h3FFFFF}, 1'b1, NONE},
        '{'{KIND_TICK, 32'h0, 16'hFFFF, 22'h3FFFFF}, 1'b1, NONE},
        '{'{KIND_TICK, KEY_THROTTLE | KEY_BRAKE | KEY_LEFT, 16'hFFFF, 22'h0}, 1'b1,
          '{16'd32767, 16'd32767, 17'd32767, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 22'h0}},
        '{'{KIND_TICK, KEY_THROTTLE | KEY_BRAKE | KEY_LEFT, 16'hFFFF, 22'h0}, 1'b1,
          '{16'd32768, 16'd32768, 17'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 22'h0}},
        '{'{KIND_TICK, ALL_KEYS, 16'h0, 22'h0}, 1'b1,
          '{16'd32768, 16'd32768, 17'd32768, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 22'h3FFFFF}},
        '{'{KIND_TICK, ALL_KEYS, 16'h0, 22'h0}, 1'b1,
          '{16'd32768, 16'd32768, 17'd32768, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 22'h3FFFFF}},
        '{'{KIND_CONSUME, 32'h0, 16'hFFFF, 22'h000001}, 1'b1,
          '{16'd32768, 16'd32768, 17'd32768, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 22'h000001}},
        '{'{KIND_CONSUME, 32'h0, 16'hFFFF, 22'h3FFFFF}, 1'b1,
          '{16'd32768, 16'd32768, 17'd32768, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 22'h3FFFFE}},
        '{'{KIND_CONSUME, 32'h0, 16'hFFFF, 22'h3FFFFF}, 1'b1,
          '{16'd32768, 16'd32768, 17'd32768, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 22'h0}},
        '{'{KIND_TICK, 32'h0, 16'hFFFF, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_RIGHT, 16'hFFFF, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_RIGHT, 16'hFFFF, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, 32'h0, 16'd1000, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, 32'h0, 16'hFFFF, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, 32'h0, 16'hFFFF, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_LEFT | KEY_RIGHT, 16'h4000, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, 32'h0, 16'hFFFF, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_TONE_LOW, 16'd10, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_TONE_HIGH, 16'd10, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_HORN_BOTH, 16'd10, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_PARK | KEY_RESET, 16'd10, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, KEY_PARK | KEY_RESET, 16'd10, 22'h0}, 1'b0, NONE},
        '{'{KIND_TICK, 32'h00AAAAAA, 16'h5555, 22'h3FFFFF}, 1'b0, NONE},
        '{'{KIND_CONSUME, 32'h0, 16'h0, 22'h155555}, 1'b0, NONE},
        '{'{KIND_TICK, 32'h00555555, 16'hAAAA, 22'h0}, 1'b0, NONE},
        '{'{KIND_CONSUME, ALL_KEYS, 16'hFFFF, 22'h3FFFFF}, 1'b0, NONE}
    };

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_idx = '0;
    logic [RATE_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_kind = KIND_TICK;
    logic [BTN_W-1:0] i_buttons = '0;
    logic [ELAP_W-1:0] i_elapsed = '0;
    logic [FLAG_W-1:0] i_consume_mask = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [LEVEL_W-1:0] o_throttle_out;
    logic [LEVEL_W-1:0] o_brake_out;
    logic signed [STEER_W-1:0] o_steering_out;
    logic o_park_brake;
    logic o_reset_pulse;
    logic o_tone_low;
    logic o_tone_high;
    logic o_quit_flag;
    logic [FLAG_W-1:0] o_pending_out;

    // control model state
    t_rates rates_now = '{RATE_RST, RATE_RST, RATE_RST, RATE_RST};
    int throttle_lvl = 0;
    int brake_lvl = 0;
    int steer_lvl = 0;
    logic park_lvl = 1'b0;
    logic quit_seen = 1'b0;
    logic [PREV_W-1:0] prev_keys = '0;
    logic [FLAG_W-1:0] flags = '0;

    t_controls controls_due [$];
    int bad_fields = 0;
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    logic [BTN_W-1:0] held_keys = '0;

    pedal_ramp_and_button_edge_latch_unit #(
        .PANEL_COUNT(PANELS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_buttons(i_buttons),
        .i_elapsed(i_elapsed),
        .i_consume_mask(i_consume_mask),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_throttle_out(o_throttle_out),
        .o_brake_out(o_brake_out),
        .o_steering_out(o_steering_out),
        .o_park_brake(o_park_brake),
        .o_reset_pulse(o_reset_pulse),
        .o_tone_low(o_tone_low),
        .o_tone_high(o_tone_high),
        .o_quit_flag(o_quit_flag),
        .o_pending_out(o_pending_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** pedal_ramp_and_button_edge_latch_unit: FAILED **");
        $finish;
    end

    function automatic int ramp_step(input logic [RATE_W-1:0] rate, input logic [ELAP_W-1:0] dt);
        logic [RATE_W+ELAP_W-1:0] prod;
        prod = ((RATE_W + ELAP_W)'(rate) * (RATE_W + ELAP_W)'(dt)) >> ELAP_W;
        return (prod > FULL) ? FULL : int'(prod);
    endfunction

    function automatic int limit(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic t_controls step_controls(input t_item it);
        t_controls r;
        logic [PREV_W-1:0] rise;
        int ts, bs, ss, rs;
        r = '0;
        if (it.kind == KIND_TICK) begin
            ts = ramp_step(rates_now.throttle, it.elapsed);
            bs = ramp_step(rates_now.brake, it.elapsed);
            ss = ramp_step(rates_now.steer, it.elapsed);
            rs = ramp_step(rates_now.steer_return, it.elapsed);
            rise = it.buttons[PREV_W-1:0] & ~prev_keys;
            throttle_lvl = limit(throttle_lvl + (it.buttons[B_THROTTLE] ? ts : -ts), 0, FULL);
            brake_lvl = limit(brake_lvl + (it.buttons[B_BRAKE] ? bs : -bs), 0, FULL);
            if (it.buttons[B_LEFT]) begin
                steer_lvl = limit(steer_lvl + ss, -FULL, FULL);
            end else if (it.buttons[B_RIGHT]) begin
                steer_lvl = limit(steer_lvl - ss, -FULL, FULL);
            end else if (steer_lvl > 0) begin
                steer_lvl = limit(steer_lvl - rs, 0, FULL);
            end else begin
                steer_lvl = limit(steer_lvl + rs, -FULL, 0);
            end
            if (rise[B_SPACE]) begin
                park_lvl = ~park_lvl;
            end
            r.rst_pulse = rise[B_RESET];
            flags = flags | (rise[FLAG_W-1:0] & LIVE_FLAGS);
            prev_keys = it.buttons[PREV_W-1:0];
            if (it.buttons[B_ESC]) begin
                quit_seen = 1'b1;
            end
            r.horn_lo = it.buttons[B_HORN_BOTH] | it.buttons[B_TONE_LOW];
            r.horn_hi = it.buttons[B_HORN_BOTH] | it.buttons[B_TONE_HIGH];
            r.pend = flags;
        end else begin
            r.pend = flags & it.mask;
            flags = flags & ~it.mask;
        end
        r.throttle = throttle_lvl[LEVEL_W-1:0];
        r.brake = brake_lvl[LEVEL_W-1:0];
        r.steer = steer_lvl[STEER_W-1:0];
        r.park = park_lvl;
        r.quit = quit_seen;
        return r;
    endfunction

    // mostly slowly changing held keys, sometimes a scrambled key vector
    function automatic t_item random_item();
        t_item it;
        it.kind = ($urandom_range(0, 7) == 0) ? KIND_CONSUME : KIND_TICK;
        it.buttons = $urandom;
        it.elapsed = ELAP_W'($urandom);
        it.mask = FLAG_W'($urandom);
        if (it.kind == KIND_CONSUME) begin
            case ($urandom_range(0, 3))
                0: it.mask = '1;
                1: it.mask = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
                default: ;
            endcase
        end else begin
            if ($urandom_range(0, 7) != 0) begin
                held_keys ^= $urandom & $urandom & $urandom;
                it.buttons = held_keys;
            end
            case ($urandom_range(0, 7))
                0: it.elapsed = '0;
                1: it.elapsed = '1;
                2, 3: ;
                default: it.elapsed = ELAP_W'($urandom_range(0, 4095));
            endcase
        end
        return it;
    endfunction

    function automatic t_rates phase_rates(input int ph);
        t_rates r;
        case (ph)
            0: r = '{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX};
            1: r = '0;
            2: r = '{RATE_W'($urandom_range(0, 4095)), RATE_W'($urandom_range(0, 4095)),
                     RATE_W'($urandom_range(0, 4095)), RATE_W'($urandom_range(0, 4095))};
            3: r = '{RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom)};
            4: r = '{RATE_MAX, '0, RATE_W'($urandom_range(0, 65535)),
                     RATE_W'($urandom_range(0, 65535))};
            5: r = '{RATE_RST, RATE_RST, RATE_RST, RATE_RST};
            default: r = '{RATE_W'($urandom_range(0, 200000)), RATE_W'($urandom_range(0, 200000)),
                           RATE_W'($urandom_range(0, 200000)), RATE_W'($urandom_range(0, 200000))};
        endcase
        return r;
    endfunction

    task automatic load_rates(input t_rates r);
        logic [RATE_W-1:0] vals [4];
        vals = '{r.throttle, r.brake, r.steer, r.steer_return};
        i_cfg_we <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_idx <= REG_ORDER[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        rates_now = r;
    endtask

    task automatic send_item(input t_item it, input logic typed, input t_controls typed_want);
        t_controls predicted;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= it.kind;
        i_buttons <= it.buttons;
        i_elapsed <= it.elapsed;
        i_consume_mask <= it.mask;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = step_controls(it);
        controls_due.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        while (controls_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_fields++;
        end
    endtask

    // receiver stalls
    initial begin
        int unsigned stall_cnt;
        stall_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (stall_cnt != 0) begin
                stall_cnt--;
            end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(1, 16);
            end
            i_out_ready <= (stall_cnt == 0) || !rx_gaps;
        end
    end

    always @(posedge i_clk) begin
        t_controls want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (controls_due.size() == 0) begin
                $error("result transaction with nothing outstanding");
                bad_fields++;
            end else begin
                want = controls_due.pop_front();
                check_field("throttle_out", want.throttle, o_throttle_out);
                check_field("brake_out", want.brake, o_brake_out);
                check_field("steering_out", int'($signed(want.steer)), int'(o_steering_out));
                check_field("park_brake", want.park, o_park_brake);
                check_field("reset_pulse", want.rst_pulse, o_reset_pulse);
                check_field("tone_low", want.horn_lo, o_tone_low);
                check_field("tone_high", want.horn_hi, o_tone_high);
                check_field("quit_flag", want.quit, o_quit_flag);
                check_field("pending_out", want.pend, o_pending_out);
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(SCRIPT); i++) begin
            send_item(SCRIPT[i].it, SCRIPT[i].typed, SCRIPT[i].want);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain(8);
            load_rates(phase_rates(ph));
            tx_gaps = (ph != 3 && ph != PHASES - 1);
            rx_gaps = tx_gaps;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    drain(0);
                end
                send_item(random_item(), 1'b0, NONE);
            end
        end

        drain(12);
        if (bad_fields == 0 && controls_due.size() == 0) begin
            $display("** pedal_ramp_and_button_edge_latch_unit: PASSED **");
        end else begin
            $display("** pedal_ramp_and_button_edge_latch_unit: FAILED **");
        end
        $finish;
    end

endmodule
